// ===== rtl/core/track_recorder_pause_control_core_assert.svh =====
// Assertion macros shared by the track recorder checker.
`ifndef TRACK_RECORDER_PAUSE_CONTROL_CORE_ASSERT_SVH
`define TRACK_RECORDER_PAUSE_CONTROL_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TRPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define TRPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked during reset.
`define TRPC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/trpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Track recorder pause control package
// Types, codes and helper functions shared by the recorder control modules.
// ----------------------------------------------------------------------------
package trpc_pkg;

    localparam int TimeBits    = 32;
    localparam int SecBits     = 16;
    localparam int MsPerSecond = 1000;
    // A 16-bit count of seconds times 1000 fits in 26 bits.
    localparam int MsBits      = SecBits + 10;
    localparam int CmpBits     = (TimeBits > MsBits) ? TimeBits : MsBits;
    localparam int FlagBits    = 5;
    localparam int CfgIdxBits  = 3;
    localparam int CfgDataBits = 16;
    localparam int InDataBits  = 72;
    localparam int OutDataBits = 16;

    // Mode flag bit positions.
    localparam int FlagStill    = 0;
    localparam int FlagNofix    = 1;
    localparam int FlagWaitFix  = 2;
    localparam int FlagAutoOff  = 3;
    localparam int FlagWaitData = 4;

    typedef enum logic [1:0] {
        MODE_STOPPED   = 2'd0,
        MODE_RECORDING = 2'd1,
        MODE_PAUSED    = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CMD_EPOCH  = 2'd0,
        CMD_START  = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        WHY_NONE     = 3'd0,
        WHY_STILL    = 3'd1,
        WHY_NOFIX    = 3'd2,
        WHY_MOVING   = 3'd3,
        WHY_REGAINED = 3'd4
    } t_reason;

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_MODE_FLAGS  = 3'd0,
        CFG_STILL_SPEED = 3'd1,
        CFG_STILL_SECS  = 3'd2,
        CFG_NOFIX_SECS  = 3'd3,
        CFG_AUTOOFF_SECS = 3'd4
    } t_cfg_idx;

    // Pause cause as kept in state: 0 no fix, 1 stationary.
    localparam logic CauseNofix = 1'b0;
    localparam logic CauseStill = 1'b1;

    typedef struct packed {
        logic [FlagBits-1:0] flags;
        logic [SecBits-1:0]  still_speed;
        logic [MsBits-1:0]   still_ms;
        logic [MsBits-1:0]   nofix_ms;
        logic [MsBits-1:0]   autooff_ms;
    } t_cfg;

    typedef struct packed {
        t_cmd                  cmd;
        logic [TimeBits-1:0]   time_ms;
        logic                  has_fix;
        logic signed [31:0]    ground_speed;
        logic                  any_stored;
    } t_item;

    typedef struct packed {
        t_mode               mode;
        logic                ever_fixed;
        logic                is_still;
        logic [TimeBits-1:0] last_fix_time;
        logic [TimeBits-1:0] still_since_time;
        logic [TimeBits-1:0] paused_since_time;
        logic                pause_cause;
    } t_state;

    typedef struct packed {
        logic    accepted;
        logic    mode_changed;
        logic    store_change;
        t_reason change_reason;
        logic    store_epoch;
        logic    power_off;
        t_mode   recorder_mode;
    } t_result;

    // Seconds to milliseconds; a constant multiply done when a register is written.
    function automatic logic [MsBits-1:0] f_sec_to_ms(input logic [SecBits-1:0] secs);
        return MsBits'(secs) * MsBits'(MsPerSecond);
    endfunction

    // Wrapping elapsed time compared with a threshold at full width.
    function automatic logic f_elapsed(input logic [TimeBits-1:0] now,
                                       input logic [TimeBits-1:0] since,
                                       input logic [MsBits-1:0]   thr_ms);
        logic [TimeBits-1:0] diff;
        diff = now - since;
        return CmpBits'(diff) >= CmpBits'(thr_ms);
    endfunction

endpackage

// ===== rtl/core/track_recorder_pause_control_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Track recorder pause control core
// Start/stop, automatic pause/resume and auto-off control for a track logger.
// ----------------------------------------------------------------------------
//  Channel  Dir  Signals                      Beat contents
//  s        in   i_s_tvalid/o_s_tready        command or position epoch
//  m        out  o_m_tvalid/i_m_tready        one result per input beat
//  cfg      in   i_cfg_wr_en/index/data       one register write per cycle
//
//  One beat is taken every cycle while the output is not stalled; a beat passes
//  the input register, then the step logic into the result register.
//  The loop through the mode/timer state passes only the state register, which sets the rate.
//  Reset clears the mode, timers and registers to zero (stopped).
//  A stalled result holds in the output register while the input register
//  keeps one more beat; back pressure reaches o_s_tready after that.
// ----------------------------------------------------------------------------
module track_recorder_pause_control_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [31:0] time_ms, [32] has_fix, [64:33] ground_speed, [65] any_stored
    input  logic [trpc_pkg::InDataBits-1:0]     i_s_tdata,
    // [1:0] cmd
    input  logic [1:0]                          i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [0] accepted, [1] mode_changed, [2] store_change, [5:3] change_reason,
    // [6] store_epoch, [7] power_off, [9:8] recorder_mode
    output logic [trpc_pkg::OutDataBits-1:0]    o_m_tdata,
    input  logic                                i_cfg_wr_en,
    input  logic [trpc_pkg::CfgIdxBits-1:0]     i_cfg_index,
    input  logic [trpc_pkg::CfgDataBits-1:0]    i_cfg_data
);

    trpc_pkg::t_cfg    r_cfg;
    trpc_pkg::t_cfg    n_cfg;
    trpc_pkg::t_state  r_state;
    trpc_pkg::t_state  n_state;
    trpc_pkg::t_item   r_item;
    trpc_pkg::t_result r_result;
    trpc_pkg::t_result n_result;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              advance;
    logic              s_beat;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign s_beat     = i_s_tvalid && o_s_tready;

    // Register writes; the seconds thresholds are kept in milliseconds.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                trpc_pkg::CFG_MODE_FLAGS:
                    n_cfg.flags = i_cfg_data[trpc_pkg::FlagBits-1:0];
                trpc_pkg::CFG_STILL_SPEED:
                    n_cfg.still_speed = i_cfg_data;
                trpc_pkg::CFG_STILL_SECS:
                    n_cfg.still_ms = trpc_pkg::f_sec_to_ms(i_cfg_data);
                trpc_pkg::CFG_NOFIX_SECS:
                    n_cfg.nofix_ms = trpc_pkg::f_sec_to_ms(i_cfg_data);
                trpc_pkg::CFG_AUTOOFF_SECS:
                    n_cfg.autooff_ms = trpc_pkg::f_sec_to_ms(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_beat) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // The time field is reduced to the time width kept in state.
    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_item.cmd          <= trpc_pkg::t_cmd'(i_s_tuser);
            r_item.time_ms      <= i_s_tdata[trpc_pkg::TimeBits-1:0];
            r_item.has_fix      <= i_s_tdata[32];
            r_item.ground_speed <= $signed(i_s_tdata[64:33]);
            r_item.any_stored   <= i_s_tdata[65];
        end
    end

    trpc_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // All-zero state is the stopped mode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_result.recorder_mode, r_result.power_off,
                         r_result.store_epoch, r_result.change_reason,
                         r_result.store_change, r_result.mode_changed,
                         r_result.accepted};

endmodule

// ===== rtl/core/trpc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Track recorder step logic
// Next mode, timers and result flags for one command or position epoch.
// ----------------------------------------------------------------------------
module trpc_step (
    input  trpc_pkg::t_cfg    i_cfg,
    input  trpc_pkg::t_state  i_state,
    input  trpc_pkg::t_item   i_item,
    output trpc_pkg::t_state  o_state,
    output trpc_pkg::t_result o_result
);

    logic slow;
    logic fix;
    logic still_hit;
    logic still_done;
    logic nofix_done;
    logic resume;
    logic autooff_hit;

    assign fix = i_item.has_fix;

    // Signed speed against the unsigned limit, one bit wider on both sides.
    assign slow = $signed({i_item.ground_speed[31], i_item.ground_speed})
                  < $signed({17'b0, i_cfg.still_speed});

    assign still_hit = i_cfg.flags[trpc_pkg::FlagStill] && fix && slow;
    assign still_done = still_hit && i_state.is_still
        && trpc_pkg::f_elapsed(i_item.time_ms, i_state.still_since_time, i_cfg.still_ms);
    assign nofix_done = !still_done && i_cfg.flags[trpc_pkg::FlagNofix] && !fix
        && trpc_pkg::f_elapsed(i_item.time_ms, i_state.last_fix_time, i_cfg.nofix_ms);
    assign resume = fix && (i_state.pause_cause == trpc_pkg::CauseNofix || !slow);
    assign autooff_hit = i_cfg.flags[trpc_pkg::FlagAutoOff]
        && trpc_pkg::f_elapsed(i_item.time_ms, i_state.paused_since_time, i_cfg.autooff_ms);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.change_reason = trpc_pkg::WHY_NONE;
        case (i_item.cmd)
            trpc_pkg::CMD_START: begin
                if (i_state.mode == trpc_pkg::MODE_STOPPED) begin
                    o_state.mode          = trpc_pkg::MODE_RECORDING;
                    o_state.ever_fixed    = 1'b0;
                    o_state.is_still      = 1'b0;
                    o_state.last_fix_time = i_item.time_ms;
                    o_result.accepted     = 1'b1;
                end
            end
            trpc_pkg::CMD_STOP: begin
                if (i_state.mode != trpc_pkg::MODE_STOPPED) begin
                    o_state.mode      = trpc_pkg::MODE_STOPPED;
                    o_result.accepted = 1'b1;
                end
            end
            trpc_pkg::CMD_EPOCH: begin
                if (fix && i_state.mode != trpc_pkg::MODE_STOPPED) begin
                    o_state.last_fix_time = i_item.time_ms;
                    o_state.ever_fixed    = 1'b1;
                end
                unique case (i_state.mode)
                    trpc_pkg::MODE_RECORDING: begin
                        if (still_hit) begin
                            if (!i_state.is_still) begin
                                o_state.is_still         = 1'b1;
                                o_state.still_since_time = i_item.time_ms;
                            end
                        end else if (fix) begin
                            o_state.is_still = 1'b0;
                        end
                        if (still_done) begin
                            o_state.mode              = trpc_pkg::MODE_PAUSED;
                            o_state.paused_since_time = i_item.time_ms;
                            o_state.pause_cause       = trpc_pkg::CauseStill;
                            o_state.is_still          = 1'b0;
                            o_result.mode_changed     = 1'b1;
                            o_result.store_change     = 1'b1;
                            o_result.change_reason    = trpc_pkg::WHY_STILL;
                        end else if (nofix_done) begin
                            o_state.mode              = trpc_pkg::MODE_PAUSED;
                            o_state.paused_since_time = i_item.time_ms;
                            o_state.pause_cause       = trpc_pkg::CauseNofix;
                            o_result.mode_changed     = 1'b1;
                            o_result.store_change     = 1'b1;
                            o_result.change_reason    = trpc_pkg::WHY_NOFIX;
                        end else begin
                            // A fix in this very epoch already counts as ever fixed.
                            o_result.store_epoch = !i_cfg.flags[trpc_pkg::FlagWaitFix]
                                                   || i_state.ever_fixed || fix;
                        end
                    end
                    trpc_pkg::MODE_PAUSED: begin
                        if (resume) begin
                            o_state.mode          = trpc_pkg::MODE_RECORDING;
                            o_state.is_still      = 1'b0;
                            o_result.mode_changed = 1'b1;
                            o_result.store_epoch  = 1'b1;
                            o_result.change_reason =
                                (i_state.pause_cause == trpc_pkg::CauseStill)
                                ? trpc_pkg::WHY_MOVING : trpc_pkg::WHY_REGAINED;
                        end else if (autooff_hit) begin
                            o_result.power_off = !(i_cfg.flags[trpc_pkg::FlagWaitData]
                                                   && !i_item.any_stored);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        o_result.recorder_mode = o_state.mode;
    end

endmodule

// ===== rtl/core/trpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Track recorder port checker
// Checks the result stream of the recorder core as seen on its ports.
// ----------------------------------------------------------------------------
`include "track_recorder_pause_control_core_assert.svh"

module trpc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [trpc_pkg::OutDataBits-1:0] o_m_tdata
);

    // A result left waiting keeps its contents.
    `TRPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // Start/stop results carry nothing but accepted and the mode.
    `TRPC_ASSERT_NOW(a_cmd_clean, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[0], o_m_tdata[7:1] == 7'd0)

    // A mode change always names its reason, and only a change does.
    `TRPC_ASSERT_NOW(a_reason_match, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[1] == (o_m_tdata[5:3] != trpc_pkg::WHY_NONE))

    // A pause record is only asked for together with the change itself.
    `TRPC_ASSERT_NOW(a_store_chg, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[2], o_m_tdata[1] && (o_m_tdata[9:8] == trpc_pkg::MODE_PAUSED))

    // Reset empties the output register.
    `TRPC_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_m_tvalid)

endmodule

bind track_recorder_pause_control_core trpc_checker u_trpc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/sv/track_recorder_pause_control_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Track recorder pause control core testbench
// Drives commands and position epochs into the core under random idling on
// both streams. A local recorder model predicts every result, and the
// results are checked field by field in order. Registers change only between
// phases, while the core is idle.
// ----------------------------------------------------------------------------
module track_recorder_pause_control_core_test;

    localparam int WatchdogLimit = 5000;
    localparam int PhaseBeats    = 64;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    // [31:0] time_ms, [32] has_fix, [64:33] ground_speed, [65] any_stored
    logic [trpc_pkg::InDataBits-1:0]  i_s_tdata = '0;
    // [1:0] cmd
    logic [1:0]                       i_s_tuser = '0;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    // [0] accepted, [1] mode_changed, [2] store_change, [5:3] change_reason,
    // [6] store_epoch, [7] power_off, [9:8] recorder_mode
    logic [trpc_pkg::OutDataBits-1:0] o_m_tdata;
    logic                             i_cfg_wr_en = 1'b0;
    logic [trpc_pkg::CfgIdxBits-1:0]  i_cfg_index = '0;
    logic [trpc_pkg::CfgDataBits-1:0] i_cfg_data = '0;

    track_recorder_pause_control_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register copies used by the recorder model.
    logic [trpc_pkg::FlagBits-1:0] cfg_flags = '0;
    logic [15:0]         cfg_still_speed = '0;
    logic [15:0]         cfg_still_secs = '0;
    logic [15:0]         cfg_nofix_secs = '0;
    logic [15:0]         cfg_autooff_secs = '0;

    // Recorder model state.
    trpc_pkg::t_mode trk_mode = trpc_pkg::MODE_STOPPED;
    logic        trk_ever_fixed = 1'b0;
    logic        trk_is_still = 1'b0;
    logic [31:0] trk_last_fix = '0;
    logic [31:0] trk_still_since = '0;
    logic [31:0] trk_paused_since = '0;
    logic        trk_cause_still = 1'b0;

    trpc_pkg::t_item   pending_beats[$];
    trpc_pkg::t_result expected_results[$];
    trpc_pkg::t_item   cur_beat;
    trpc_pkg::t_result want_result;
    trpc_pkg::t_result seen_result;

    int send_idle_pct = 8;
    int recv_idle_pct = 48;
    int fail_count = 0;
    int beats_in = 0;
    int results_out = 0;
    int pauses_seen = 0;
    int resumes_seen = 0;
    int poweroffs_seen = 0;
    int stall_cycles = 0;
    logic [31:0] clock_ms = '0;

    function automatic logic span_reached(input logic [31:0] now, input logic [31:0] since,
                                          input logic [15:0] secs);
        logic [31:0] gap;
        gap = now - since;
        return 64'(gap) >= 64'(secs) * 64'(trpc_pkg::MsPerSecond);
    endfunction

    function automatic trpc_pkg::t_result step_recorder(input trpc_pkg::t_item b);
        trpc_pkg::t_result r;
        logic    slow;
        logic    halted;
        longint  spd;
        r = '0;
        r.change_reason = trpc_pkg::WHY_NONE;
        spd = longint'(b.ground_speed);
        slow = spd < longint'(cfg_still_speed);
        halted = 1'b0;
        case (b.cmd)
            trpc_pkg::CMD_START: begin
                if (trk_mode == trpc_pkg::MODE_STOPPED) begin
                    trk_mode = trpc_pkg::MODE_RECORDING;
                    trk_ever_fixed = 1'b0;
                    trk_is_still = 1'b0;
                    trk_last_fix = b.time_ms;
                    r.accepted = 1'b1;
                end
            end
            trpc_pkg::CMD_STOP: begin
                if (trk_mode != trpc_pkg::MODE_STOPPED) begin
                    trk_mode = trpc_pkg::MODE_STOPPED;
                    r.accepted = 1'b1;
                end
            end
            trpc_pkg::CMD_EPOCH: begin
                if (trk_mode != trpc_pkg::MODE_STOPPED) begin
                    if (b.has_fix) begin
                        trk_last_fix = b.time_ms;
                        trk_ever_fixed = 1'b1;
                    end
                    if (trk_mode == trpc_pkg::MODE_RECORDING) begin
                        if (cfg_flags[trpc_pkg::FlagStill] && b.has_fix && slow) begin
                            if (!trk_is_still) begin
                                trk_is_still = 1'b1;
                                trk_still_since = b.time_ms;
                            end else if (span_reached(b.time_ms, trk_still_since,
                                                      cfg_still_secs)) begin
                                trk_mode = trpc_pkg::MODE_PAUSED;
                                trk_paused_since = b.time_ms;
                                trk_cause_still = trpc_pkg::CauseStill;
                                r.mode_changed = 1'b1;
                                r.store_change = 1'b1;
                                r.change_reason = trpc_pkg::WHY_STILL;
                                trk_is_still = 1'b0;
                                halted = 1'b1;
                            end
                        end else if (b.has_fix) begin
                            trk_is_still = 1'b0;
                        end
                        if (!halted && cfg_flags[trpc_pkg::FlagNofix] && !b.has_fix &&
                            span_reached(b.time_ms, trk_last_fix, cfg_nofix_secs)) begin
                            trk_mode = trpc_pkg::MODE_PAUSED;
                            trk_paused_since = b.time_ms;
                            trk_cause_still = trpc_pkg::CauseNofix;
                            r.mode_changed = 1'b1;
                            r.store_change = 1'b1;
                            r.change_reason = trpc_pkg::WHY_NOFIX;
                            halted = 1'b1;
                        end
                        if (!halted)
                            r.store_epoch = !cfg_flags[trpc_pkg::FlagWaitFix]
                                            || trk_ever_fixed;
                    end else begin
                        if (b.has_fix && (trk_cause_still == trpc_pkg::CauseNofix || !slow))
                        begin
                            trk_mode = trpc_pkg::MODE_RECORDING;
                            trk_is_still = 1'b0;
                            r.mode_changed = 1'b1;
                            r.change_reason = trk_cause_still ? trpc_pkg::WHY_MOVING
                                                              : trpc_pkg::WHY_REGAINED;
                            r.store_epoch = 1'b1;
                        end else if (cfg_flags[trpc_pkg::FlagAutoOff] &&
                                     span_reached(b.time_ms, trk_paused_since,
                                                  cfg_autooff_secs)) begin
                            r.power_off = !(cfg_flags[trpc_pkg::FlagWaitData]
                                            && !b.any_stored);
                        end
                    end
                end
            end
            default: ;
        endcase
        r.recorder_mode = trk_mode;
        return r;
    endfunction

    function automatic trpc_pkg::t_item make_beat(input trpc_pkg::t_cmd c,
                                                  input logic [31:0] t, input logic fix,
                                                  input logic signed [31:0] spd,
                                                  input logic stored);
        trpc_pkg::t_item b;
        b.cmd = c;
        b.time_ms = t;
        b.has_fix = fix;
        b.ground_speed = spd;
        b.any_stored = stored;
        return b;
    endfunction

    // Mostly epochs with time moving forward in small steps, so that pauses,
    // resumes and timeouts are reached; now and then a jump to any time.
    function automatic trpc_pkg::t_item random_beat();
        int   pick;
        trpc_pkg::t_cmd c;
        logic signed [31:0] spd;
        pick = $urandom_range(99);
        if (pick < 6)
            c = trpc_pkg::CMD_START;
        else if (pick < 9)
            c = trpc_pkg::CMD_STOP;
        else if (pick < 13)
            c = trpc_pkg::CMD_UNUSED;
        else
            c = trpc_pkg::CMD_EPOCH;
        if ($urandom_range(99) < 3)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + $urandom_range(0, 1500);
        pick = $urandom_range(99);
        if (pick < 45)
            spd = $signed($urandom_range(0, 32'(cfg_still_speed) * 2 + 1));
        else if (pick < 60)
            spd = $signed($urandom());
        else if (pick < 70)
            spd = -$signed(32'($urandom_range(0, 1000)));
        else
            spd = $signed(32'(cfg_still_speed) + $urandom_range(0, 500));
        return make_beat(c, clock_ms, $urandom_range(99) < 75, spd, 1'($urandom_range(1)));
    endfunction

    task automatic write_reg(input trpc_pkg::t_cfg_idx idx,
                             input logic [trpc_pkg::CfgDataBits-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
    endtask

    task automatic set_config(input logic [4:0] flags, input logic [15:0] speed,
                              input logic [15:0] still, input logic [15:0] nofix,
                              input logic [15:0] autooff);
        write_reg(trpc_pkg::CFG_MODE_FLAGS, trpc_pkg::CfgDataBits'(flags));
        write_reg(trpc_pkg::CFG_STILL_SPEED, speed);
        write_reg(trpc_pkg::CFG_STILL_SECS, still);
        write_reg(trpc_pkg::CFG_NOFIX_SECS, nofix);
        write_reg(trpc_pkg::CFG_AUTOOFF_SECS, autooff);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_flags = flags;
        cfg_still_speed = speed;
        cfg_still_secs = still;
        cfg_nofix_secs = nofix;
        cfg_autooff_secs = autooff;
    endtask

    // Waits until every beat has gone in and every result has come out, then
    // lets the two-stage pipeline drain.
    task automatic wait_idle();
        while (pending_beats.size() != 0 || expected_results.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Stream driver: the beat stays on the bus until it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                expected_results.push_back(step_recorder(cur_beat));
                beats_in++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_beat = pending_beats.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {6'b0, cur_beat.any_stored, cur_beat.ground_speed,
                                   cur_beat.has_fix, cur_beat.time_ms};
                    i_s_tuser  <= cur_beat.cmd;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                results_out++;
                seen_result.accepted      = o_m_tdata[0];
                seen_result.mode_changed  = o_m_tdata[1];
                seen_result.store_change  = o_m_tdata[2];
                seen_result.change_reason = trpc_pkg::t_reason'(o_m_tdata[5:3]);
                seen_result.store_epoch   = o_m_tdata[6];
                seen_result.power_off     = o_m_tdata[7];
                seen_result.recorder_mode = trpc_pkg::t_mode'(o_m_tdata[9:8]);
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat: expected none, actual %0h",
                             $time, o_m_tdata);
                end else begin
                    want_result = expected_results.pop_front();
                    check_field("accepted", 32'(want_result.accepted),
                                32'(seen_result.accepted));
                    check_field("mode_changed", 32'(want_result.mode_changed),
                                32'(seen_result.mode_changed));
                    check_field("store_change", 32'(want_result.store_change),
                                32'(seen_result.store_change));
                    check_field("change_reason", 32'(want_result.change_reason),
                                32'(seen_result.change_reason));
                    check_field("store_epoch", 32'(want_result.store_epoch),
                                32'(seen_result.store_epoch));
                    check_field("power_off", 32'(want_result.power_off),
                                32'(seen_result.power_off));
                    check_field("recorder_mode", 32'(want_result.recorder_mode),
                                32'(seen_result.recorder_mode));
                    if (want_result.mode_changed &&
                        want_result.recorder_mode == trpc_pkg::MODE_PAUSED)
                        pauses_seen++;
                    if (want_result.mode_changed &&
                        want_result.recorder_mode == trpc_pkg::MODE_RECORDING)
                        resumes_seen++;
                    if (want_result.power_off)
                        poweroffs_seen++;
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (pending_beats.size() == 0 && expected_results.size() == 0 && !i_s_tvalid))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WatchdogLimit) begin
                $display("%0t: timeout with %0d results outstanding", $time,
                         expected_results.size());
                $display("Some tests failed");
                $finish;
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: every command, both pause causes, both resume
        // reasons, auto-off held back by missing data, and time wrap.
        set_config(5'h1F, 16'd100, 16'd1, 16'd2, 16'd0);
        pending_beats.push_back(make_beat(trpc_pkg::CMD_UNUSED, 32'd0, 1'b1, 32'sd0, 1'b1));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_EPOCH, 32'hFFFF_FFFF, 1'b1,
                                          32'sh8000_0000, 1'b1));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_STOP, 32'd10, 1'b0, 32'sd0, 1'b0));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_START, 32'd1000, 1'b0, 32'sd0, 1'b0));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_START, 32'd1050, 1'b1, 32'sd0, 1'b0));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_EPOCH, 32'd1100, 1'b0,
                                          32'sh7FFF_FFFF, 1'b0));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_EPOCH, 32'd1200, 1'b1, 32'sd5000, 1'b0));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_EPOCH, 32'd1300, 1'b1, 32'sd10, 1'b0));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_EPOCH, 32'd2300, 1'b1, 32'sd99, 1'b1));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_EPOCH, 32'd2400, 1'b1, 32'sd0, 1'b0));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_EPOCH, 32'd2450, 1'b0, 32'sd0, 1'b1));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_EPOCH, 32'd2500, 1'b1, 32'sd100, 1'b1));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_EPOCH, 32'd2600, 1'b0, 32'sd0, 1'b0));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_EPOCH, 32'd4600, 1'b0, 32'sd0, 1'b0));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_EPOCH, 32'd4700, 1'b1, -32'sd5, 1'b0));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_UNUSED, 32'd4800, 1'b1, 32'sd0, 1'b0));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_STOP, 32'd4900, 1'b1, 32'sd0, 1'b0));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_START, 32'hFFFF_FF00, 1'b1,
                                          32'sd0, 1'b0));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_EPOCH, 32'h0000_0100, 1'b0,
                                          32'sd0, 1'b0));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_EPOCH, 32'h0000_0200, 1'b1,
                                          32'sd3, 1'b1));
        pending_beats.push_back(make_beat(trpc_pkg::CMD_STOP, 32'h0000_0300, 1'b0,
                                          32'sd0, 1'b1));
        wait_idle();

        // Random phases, each opening with a start so most beats see an
        // active recorder.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(5'h00, 16'd0, 16'd0, 16'd0, 16'd0);
                1: set_config(5'h1F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: set_config(5'($urandom_range(0, 31)), 16'($urandom_range(0, 3000)),
                                    16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                                    16'($urandom_range(0, 8)));
            endcase
            send_idle_pct = (ph < 2) ? 8 : (ph < 4) ? 48 : 0;
            recv_idle_pct = (ph < 2) ? 48 : (ph < 4) ? 8 : 0;
            clock_ms = clock_ms + $urandom_range(0, 1000);
            pending_beats.push_back(make_beat(trpc_pkg::CMD_START, clock_ms, 1'b1,
                                              32'sd0, 1'b0));
            for (int n = 0; n < PhaseBeats; n++)
                pending_beats.push_back(random_beat());
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            fail_count++;
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end
        $display("Covered %0d beats and %0d results over seven register settings.",
                 beats_in, results_out);
        $display("Saw %0d pauses, %0d resumes and %0d power-off requests.",
                 pauses_seen, resumes_seen, poweroffs_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
